// ===== hw/rtl/pcpt_pkg.sv =====
package pcpt_pkg;

  localparam int PW = 35;
  localparam int WW = 37;

  typedef enum logic [7:0] {
    REG_QUAT_W        = 8'd0,
    REG_QUAT_X        = 8'd1,
    REG_QUAT_Y        = 8'd2,
    REG_QUAT_Z        = 8'd3,
    REG_SHIFT_X       = 8'd4,
    REG_SHIFT_Y       = 8'd5,
    REG_SHIFT_Z       = 8'd6,
    REG_CAMERA_OFFSET = 8'd7
  } reg_index_t;

  localparam logic signed [24:0] PITCH_COS = 25'sd15891551;
  localparam logic signed [24:0] PITCH_SIN = 25'sd5378994;
  localparam int PITCH_FRAC = 24;
  localparam int ROT_FRAC = 28;
  localparam logic signed [31:0] ROT_ONE = 32'sd268435456;
  localparam logic signed [15:0] Q_LIMIT = 16'sd16384;

  typedef logic signed [PW-1:0] pcoord_t;
  typedef logic signed [WW-1:0] wcoord_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [15:0] off_z;
  } pose_t;

  typedef struct packed {
    pcoord_t x;
    pcoord_t y;
    pcoord_t z;
    logic    last;
  } bpoint_t;

  typedef struct packed {
    wcoord_t x;
    wcoord_t y;
    wcoord_t z;
    logic    last;
  } wpoint_t;

endpackage

// ===== hw/rtl/pcpt_cfg.sv =====
module pcpt_cfg
  import pcpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output pose_t       pose
);

  function automatic logic signed [15:0] clamp_q(input logic signed [15:0] q);
    if (q > Q_LIMIT) return Q_LIMIT;
    if (q < -Q_LIMIT) return -Q_LIMIT;
    return q;
  endfunction

  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0] shift_x, shift_y, shift_z;
  logic [47:0]        camera_offset;

  logic signed [15:0] cw, cx, cy, cz;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w        <= Q_LIMIT;
      quat_x        <= '0;
      quat_y        <= '0;
      quat_z        <= '0;
      shift_x       <= '0;
      shift_y       <= '0;
      shift_z       <= '0;
      camera_offset <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_QUAT_W:        quat_w <= cfg_data[15:0];
        REG_QUAT_X:        quat_x <= cfg_data[15:0];
        REG_QUAT_Y:        quat_y <= cfg_data[15:0];
        REG_QUAT_Z:        quat_z <= cfg_data[15:0];
        REG_SHIFT_X:       shift_x <= cfg_data[31:0];
        REG_SHIFT_Y:       shift_y <= cfg_data[31:0];
        REG_SHIFT_Z:       shift_z <= cfg_data[31:0];
        REG_CAMERA_OFFSET: camera_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cw = clamp_q(quat_w);
  assign cx = clamp_q(quat_x);
  assign cy = clamp_q(quat_y);
  assign cz = clamp_q(quat_z);

  // quaternion products, Q4.28
  always_ff @(posedge clk) begin
    xx <= 32'(cx) * 32'(cx);
    yy <= 32'(cy) * 32'(cy);
    zz <= 32'(cz) * 32'(cz);
    xy <= 32'(cx) * 32'(cy);
    xz <= 32'(cx) * 32'(cz);
    yz <= 32'(cy) * 32'(cz);
    wx <= 32'(cw) * 32'(cx);
    wy <= 32'(cw) * 32'(cy);
    wz <= 32'(cw) * 32'(cz);
  end

  always_ff @(posedge clk) begin
    r00 <= ROT_ONE - ((yy + zz) <<< 1);
    r01 <= (xy - wz) <<< 1;
    r02 <= (xz + wy) <<< 1;
    r10 <= (xy + wz) <<< 1;
    r11 <= ROT_ONE - ((xx + zz) <<< 1);
    r12 <= (yz - wx) <<< 1;
    r20 <= (xz - wy) <<< 1;
    r21 <= (yz + wx) <<< 1;
    r22 <= ROT_ONE - ((xx + yy) <<< 1);
  end

  always_comb begin
    pose.r00     = r00;
    pose.r01     = r01;
    pose.r02     = r02;
    pose.r10     = r10;
    pose.r11     = r11;
    pose.r12     = r12;
    pose.r20     = r20;
    pose.r21     = r21;
    pose.r22     = r22;
    pose.shift_x = shift_x;
    pose.shift_y = shift_y;
    pose.shift_z = shift_z;
    pose.off_x   = camera_offset[15:0];
    pose.off_y   = camera_offset[31:16];
    pose.off_z   = camera_offset[47:32];
  end

endmodule

// ===== hw/rtl/pcpt_pitch.sv =====
module pcpt_pitch
  import pcpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  pose_t              pose,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output bpoint_t            bp
);

  localparam logic signed [58:0] PITCH_HALF = 59'sd1 <<< (PITCH_FRAC - 1);

  logic               v1;
  logic               ready1, ready2;
  logic signed [32:0] bx, by, bz;
  logic signed [57:0] cbx, sbz, cbz, sbx;
  logic signed [32:0] by1;
  logic               last1;
  logic signed [58:0] sum_x, sum_z;

  // body frame: (x,y,z) -> (z,-x,-y)
  assign bx = {point_z[31], point_z};
  assign by = -$signed({point_x[31], point_x});
  assign bz = -$signed({point_y[31], point_y});

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      cbx   <= 58'(PITCH_COS) * 58'(bx);
      sbz   <= 58'(PITCH_SIN) * 58'(bz);
      cbz   <= 58'(PITCH_COS) * 58'(bz);
      sbx   <= 58'(PITCH_SIN) * 58'(bx);
      by1   <= by;
      last1 <= last_in;
    end
  end

  assign sum_x = 59'(cbx) + 59'(sbz) + PITCH_HALF;
  assign sum_z = 59'(cbz) - 59'(sbx) + PITCH_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      bp.x    <= PW'(sum_x >>> PITCH_FRAC) + (PW'(pose.off_x) <<< 8);
      bp.y    <= PW'(by1) + (PW'(pose.off_y) <<< 8);
      bp.z    <= PW'(sum_z >>> PITCH_FRAC) + (PW'(pose.off_z) <<< 8);
      bp.last <= last1;
    end
  end

endmodule

// ===== hw/rtl/pcpt_rot.sv =====
module pcpt_rot
  import pcpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  pose_t   pose,
  input  logic    in_valid,
  output logic    in_ready,
  input  bpoint_t bp,
  output logic    out_valid,
  input  logic    out_ready,
  output wpoint_t wp
);

  localparam logic signed [63:0] ROT_HALF = 64'sd1 <<< (ROT_FRAC - 1);

  logic               v3;
  logic               ready3, ready4;
  logic signed [63:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic               last3;
  logic signed [63:0] acc_x, acc_y, acc_z;

  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready3) begin
      m00   <= 64'(pose.r00) * 64'(bp.x);
      m01   <= 64'(pose.r01) * 64'(bp.y);
      m02   <= 64'(pose.r02) * 64'(bp.z);
      m10   <= 64'(pose.r10) * 64'(bp.x);
      m11   <= 64'(pose.r11) * 64'(bp.y);
      m12   <= 64'(pose.r12) * 64'(bp.z);
      m20   <= 64'(pose.r20) * 64'(bp.x);
      m21   <= 64'(pose.r21) * 64'(bp.y);
      m22   <= 64'(pose.r22) * 64'(bp.z);
      last3 <= bp.last;
    end
  end

  // row sums keep full precision in 64 bits
  assign acc_x = m00 + m01 + m02 + ROT_HALF;
  assign acc_y = m10 + m11 + m12 + ROT_HALF;
  assign acc_z = m20 + m21 + m22 + ROT_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && ready4) begin
      wp.x    <= WW'(acc_x >>> ROT_FRAC) + WW'(pose.shift_x);
      wp.y    <= WW'(acc_y >>> ROT_FRAC) + WW'(pose.shift_y);
      wp.z    <= WW'(acc_z >>> ROT_FRAC) + WW'(pose.shift_z);
      wp.last <= last3;
    end
  end

endmodule

// ===== hw/rtl/point_cloud_pose_transform.sv =====
// A request passes through five register stages from acceptance to out_valid.
// Throughput: one request per cycle; a stalled output holds the pipeline once its
// five stages are full.
// A configuration write takes effect on requests accepted from the next cycle on
// (rotation matrix is rebuilt through two register stages).
// Synchronous reset empties the pipeline and loads the identity pose.
module point_cloud_pose_transform
  import pcpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic               last_out
);

  function automatic logic signed [31:0] sat32(input logic signed [WW:0] v);
    if (&v[WW:31] || ~|v[WW:31]) return v[31:0];
    return v[WW] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  pose_t           pose;
  bpoint_t         bp;
  wpoint_t         wp;
  logic            bp_valid, bp_ready;
  logic            wp_valid, wp_ready;
  logic signed [WW:0] ext_x, ext_y, ext_z;

  pcpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pose      (pose)
  );

  pcpt_pitch u_pitch (
    .clk       (clk),
    .rst       (rst),
    .pose      (pose),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .last_in   (last_in),
    .out_valid (bp_valid),
    .out_ready (bp_ready),
    .bp        (bp)
  );

  pcpt_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .pose      (pose),
    .in_valid  (bp_valid),
    .in_ready  (bp_ready),
    .bp        (bp),
    .out_valid (wp_valid),
    .out_ready (wp_ready),
    .wp        (wp)
  );

  assign ext_x = {wp.x[WW-1], wp.x};
  assign ext_y = {wp.y[WW-1], wp.y};
  assign ext_z = {wp.z[WW-1], wp.z};

  assign wp_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wp_ready) begin
      out_valid <= wp_valid;
    end
  end

  // output frame: (x,y,z) -> (-y,-z,x)
  always_ff @(posedge clk) begin
    if (wp_valid && wp_ready) begin
      world_x  <= sat32(-ext_y);
      world_y  <= sat32(-ext_z);
      world_z  <= sat32(ext_x);
      last_out <= wp.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("pipeline stalls with an empty output stage");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (rst) !wp_valid |-> bp_ready)
    else $error("rotation stage stalls with nothing ahead of it");

endmodule

// ===== verif/pose_transform_check.sv =====
`timescale 1ns / 1ps

module pose_transform_check
  import pcpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic               last_out,
  output int                 mismatches,
  output int                 outstanding
);

  typedef logic signed [79:0] acc_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } world_point_t;

  logic [15:0]  quat_w, quat_x, quat_y, quat_z;
  logic [31:0]  shift_x, shift_y, shift_z;
  logic [47:0]  cam_offset;
  world_point_t expected_points [$];
  world_point_t want;

  initial begin
    mismatches = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  // floor((v + 2^(n-1)) / 2^n)
  function automatic acc_t round_shift(input acc_t v, input int n);
    return (v + (acc_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic acc_t quat_term(input logic [15:0] raw);
    acc_t q, lim;
    q = acc_t'($signed(raw));
    lim = acc_t'(Q_LIMIT);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic logic [31:0] clamp_world(input acc_t v);
    acc_t hi, lo;
    hi = acc_t'(32'sh7FFFFFFF);
    lo = -hi - 1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

  function automatic world_point_t transform_point(input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z,
                                                   input logic last);
    acc_t bx, by, bz, px, py, pz, c, s, one;
    acc_t qw, qx, qy, qz;
    acc_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
    acc_t rot_x, rot_y, rot_z;
    world_point_t w;
    bx = acc_t'(z);
    by = -acc_t'(x);
    bz = -acc_t'(y);
    c = acc_t'(PITCH_COS);
    s = acc_t'(PITCH_SIN);
    px = round_shift(c * bx + s * bz, PITCH_FRAC) + acc_t'($signed(cam_offset[15:0])) * 256;
    py = by + acc_t'($signed(cam_offset[31:16])) * 256;
    pz = round_shift(c * bz - s * bx, PITCH_FRAC) + acc_t'($signed(cam_offset[47:32])) * 256;
    qw = quat_term(quat_w);
    qx = quat_term(quat_x);
    qy = quat_term(quat_y);
    qz = quat_term(quat_z);
    one = acc_t'(ROT_ONE);
    r00 = one - 2 * (qy * qy + qz * qz);
    r01 = 2 * (qx * qy - qw * qz);
    r02 = 2 * (qx * qz + qw * qy);
    r10 = 2 * (qx * qy + qw * qz);
    r11 = one - 2 * (qx * qx + qz * qz);
    r12 = 2 * (qy * qz - qw * qx);
    r20 = 2 * (qx * qz - qw * qy);
    r21 = 2 * (qy * qz + qw * qx);
    r22 = one - 2 * (qx * qx + qy * qy);
    rot_x = round_shift(r00 * px + r01 * py + r02 * pz, ROT_FRAC) + acc_t'($signed(shift_x));
    rot_y = round_shift(r10 * px + r11 * py + r12 * pz, ROT_FRAC) + acc_t'($signed(shift_y));
    rot_z = round_shift(r20 * px + r21 * py + r22 * pz, ROT_FRAC) + acc_t'($signed(shift_z));
    w.x = clamp_world(-rot_y);
    w.y = clamp_world(-rot_z);
    w.z = clamp_world(rot_x);
    w.last = last;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      quat_w <= 16'h4000;
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
      cam_offset <= '0;
      expected_points.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUAT_W:        quat_w <= cfg_data[15:0];
          REG_QUAT_X:        quat_x <= cfg_data[15:0];
          REG_QUAT_Y:        quat_y <= cfg_data[15:0];
          REG_QUAT_Z:        quat_z <= cfg_data[15:0];
          REG_SHIFT_X:       shift_x <= cfg_data[31:0];
          REG_SHIFT_Y:       shift_y <= cfg_data[31:0];
          REG_SHIFT_Z:       shift_z <= cfg_data[31:0];
          REG_CAMERA_OFFSET: cam_offset <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_points.insert(expected_points.size(),
                               transform_point(point_x, point_y, point_z, last_in));
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected result (%0d, %0d, %0d)",
                                    world_x, world_y, world_z));
        end else begin
          want = expected_points.pop_front();
          if (world_x !== want.x)
            report_mismatch($sformatf("world_x %0d, expected %0d", world_x, want.x));
          if (world_y !== want.y)
            report_mismatch($sformatf("world_y %0d, expected %0d", world_y, want.y));
          if (world_z !== want.z)
            report_mismatch($sformatf("world_z %0d, expected %0d", world_z, want.z));
          if (last_out !== want.last)
            report_mismatch($sformatf("last_out %b, expected %b", last_out, want.last));
        end
      end
      outstanding <= expected_points.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pcpt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [47:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               last_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic               last_out;
  int                 mismatches;
  int                 outstanding;
  int                 cycle_count = 0;
  bit                 calm;
  bit                 hold_req;

  point_cloud_pose_transform dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .world_x   (world_x),
    .world_y   (world_y),
    .world_z   (world_z),
    .last_out  (last_out)
  );

  pose_transform_check pose_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .last_in     (last_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .world_x     (world_x),
    .world_y     (world_y),
    .world_z     (world_z),
    .last_out    (last_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        held = 300;
      end
      if (held > 0) begin
        held = held - 1;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic put_reg(input logic [7:0] idx, input logic [47:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic last);
    if (!calm && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    point_x <= x;
    point_y <= y;
    point_z <= z;
    last_in <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] extremes [5];
    extremes = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF};
    case ($urandom_range(7))
      0, 1:    return $urandom;
      2, 3, 4: return 32'($urandom_range(2097152)) - 32'd1048576;
      5:       return extremes[$urandom_range(4)];
      default: return 32'($urandom_range(524288)) - 32'd262144;
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(8388608)) - 32'd4194304;
  endfunction

  // w in bits 15:0, then x, y, z
  function automatic logic [63:0] unit_quat();
    real c [4];
    real n;
    logic [63:0] q;
    for (int i = 0; i < 4; i++) c[i] = $itor($urandom_range(2000)) - 1000.0;
    n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    if (n < 1.0) begin
      c[0] = 1.0;
      n = 1.0;
    end
    for (int i = 0; i < 4; i++) q[16 * i +: 16] = 16'($rtoi(c[i] / n * 16384.0));
    return q;
  endfunction

  initial begin
    logic [31:0] corner [12];
    logic [63:0] quats;
    logic [31:0] sx, sy, sz;
    logic [47:0] cam, junk;
    int p, k;
    corner = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
               32'hFFFF0000, 32'hAAAAAAAA, 32'h55555555, 32'h00008000, 32'hFFFF8000,
               32'h7FFF0000};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    last_in = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < 20; k++)
      send_point(corner[k % 12], corner[(k + 5) % 12], corner[(k + 7) % 12], k[0]);
    in_valid <= 1'b0;

    for (p = 0; p < 14; p++) begin
      wait_drained();
      junk = 48'({$urandom, $urandom});
      case (p)
        0: begin
          quats = 64'h0000_0000_0000_4000;
          sx = pick_shift();
          sy = pick_shift();
          sz = pick_shift();
          cam = 48'({$urandom, $urandom});
        end
        1: begin
          quats = {4{16'h4000}};
          sx = 32'h7FFFFFFF;
          sy = 32'h7FFFFFFF;
          sz = 32'h7FFFFFFF;
          cam = {3{16'h7FFF}};
        end
        2: begin
          quats = {4{16'hC000}};
          sx = 32'h80000000;
          sy = 32'h80000000;
          sz = 32'h80000000;
          cam = {3{16'h8000}};
        end
        3: begin
          quats = {16'h8000, 16'h7FFF, 16'hBFFF, 16'h4001};
          sx = '0;
          sy = '0;
          sz = '0;
          cam = '0;
        end
        default: begin
          case ($urandom_range(3))
            0, 1: quats = unit_quat();
            2: begin
              for (k = 0; k < 4; k++)
                quats[16 * k +: 16] = 16'($urandom_range(32768)) - 16'd16384;
            end
            default: quats = {$urandom, $urandom};
          endcase
          sx = pick_shift();
          sy = pick_shift();
          sz = pick_shift();
          cam = 48'({$urandom, $urandom});
        end
      endcase
      put_reg(REG_QUAT_W, {junk[47:16], quats[15:0]});
      put_reg(REG_QUAT_X, {junk[47:16], quats[31:16]});
      put_reg(REG_QUAT_Y, {junk[47:16], quats[47:32]});
      put_reg(REG_QUAT_Z, {junk[47:16], quats[63:48]});
      put_reg(REG_SHIFT_X, {junk[47:32], sx});
      put_reg(REG_SHIFT_Y, {junk[47:32], sy});
      put_reg(REG_SHIFT_Z, {junk[47:32], sz});
      put_reg(REG_CAMERA_OFFSET, cam);
      if (p == 3 || $urandom_range(1) == 1)
        put_reg(8'($urandom_range(255, REG_CAMERA_OFFSET + 1)), junk);
      cfg_valid <= 1'b0;

      calm = (p == 5 || p == 6);
      hold_req = (p == 7);
      for (k = 0; k < 90; k++)
        send_point(pick_coord(), pick_coord(), pick_coord(),
                   k == 89 || $urandom_range(15) == 0);
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pcpt_pkg.sv
hw/rtl/pcpt_cfg.sv
hw/rtl/pcpt_pitch.sv
hw/rtl/pcpt_rot.sv
hw/rtl/point_cloud_pose_transform.sv
verif/pose_transform_check.sv
verif/testbench.sv
